@@ sv/sir_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table for the sinc reconstructor.
package sir_pkg;

    localparam int MAX_POINTS    = 64;
    localparam int CORDIC_STEPS  = 24;
    localparam int CORDIC_IW     = 5;
    localparam int CORDIC_W      = 34;
    localparam int DIV_W         = 48;
    localparam int DIV_CW        = 6;
    localparam int U_W           = 49;
    localparam int SUM_W         = 48;

    localparam logic [31:0] PI_Q30          = 32'd3373259426;
    localparam logic [28:0] INV_PI_Q30      = 29'd341782638;
    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
    localparam logic [30:0] Q30_ONE         = 31'h4000_0000;

    localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd0;
    localparam logic [1:0] CFG_START_TIME    = 2'd1;
    localparam logic [1:0] CFG_TIME_STEP     = 2'd2;
    localparam logic [1:0] CFG_OUT_COUNT     = 2'd3;

    typedef struct packed {
        logic accept;
        logic run_init;
        logic div_time;
        logic r_capture;
        logic mem_read;
        logic classify;
        logic cordic_step;
        logic w_calc;
        logic div_sinc;
        logic sinc_capture;
        logic term_mul;
        logic accumulate;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic special;
        logic cordic_last;
        logic k_last;
        logic pt_last;
        logic out_busy;
    } t_sts;

    function automatic logic [CORDIC_W-1:0] atan_q30(input logic [CORDIC_IW-1:0] idx);
        logic [CORDIC_W-1:0] v;
        unique case (idx)
            5'd0:  v = 34'h3243F6A8;
            5'd1:  v = 34'h1DAC6705;
            5'd2:  v = 34'h0FADBAFC;
            5'd3:  v = 34'h07F56EA6;
            5'd4:  v = 34'h03FEAB76;
            5'd5:  v = 34'h01FFD55B;
            5'd6:  v = 34'h00FFFAAA;
            5'd7:  v = 34'h007FFF55;
            5'd8:  v = 34'h003FFFEA;
            5'd9:  v = 34'h001FFFFD;
            5'd10: v = 34'h000FFFFF;
            5'd11: v = 34'h0007FFFF;
            5'd12: v = 34'h0003FFFF;
            5'd13: v = 34'h0001FFFF;
            5'd14: v = 34'h0000FFFF;
            5'd15: v = 34'h00007FFF;
            5'd16: v = 34'h00003FFF;
            5'd17: v = 34'h00001FFF;
            5'd18: v = 34'h00000FFF;
            5'd19: v = 34'h000007FF;
            5'd20: v = 34'h000003FF;
            5'd21: v = 34'h000001FF;
            5'd22: v = 34'h000000FF;
            5'd23: v = 34'h0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/sir_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module sir_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sir_pkg::DIV_W-1:0]  i_dividend,
    input  logic [sir_pkg::DIV_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [sir_pkg::DIV_W-1:0]  o_quotient,
    output logic                       o_rem_nz
);
    import sir_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_W-1:0]  r_quo;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dvs;
    logic [DIV_W:0]    rem_sh;
    logic [DIV_W+1:0]  diff;
    logic              ge;

    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
    assign ge     = ~diff[DIV_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == DIV_CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
    assign o_rem_nz   = (r_rem != '0);

endmodule

@@ sv/sir_dp.sv @@
// Datapath: config registers, sample memory, time divide, CORDIC sine, sinc divide, accumulator.
module sir_dp #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic signed [15:0]   i_sample,
    input  sir_pkg::t_cmd        i_cmd,
    output sir_pkg::t_sts        o_sts,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic signed [31:0]   o_value,
    output logic                 o_saturated,
    output logic                 o_last_output
);
    import sir_pkg::*;

    localparam int KW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    // configuration
    logic [30:0]        r_cfg_per;
    logic signed [31:0] r_cfg_start;
    logic [30:0]        r_cfg_step;
    logic [6:0]         r_cfg_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_per   <= 31'd65536;
            r_cfg_start <= '0;
            r_cfg_step  <= 31'd65536;
            r_cfg_cnt   <= 7'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_PERIOD: r_cfg_per   <= i_cfg_data[30:0];
                CFG_START_TIME:    r_cfg_start <= i_cfg_data;
                CFG_TIME_STEP:     r_cfg_step  <= i_cfg_data[30:0];
                CFG_OUT_COUNT:     r_cfg_cnt   <= i_cfg_data[6:0];
            endcase
        end
    end

    // sample memory
    logic signed [15:0] r_mem [MAX_SAMPLES];
    logic signed [15:0] r_rd;
    logic [CW-1:0]      r_cnt;
    logic [KW-1:0]      r_k;
    logic               wr_en;

    assign wr_en = i_cmd.accept && (r_cnt < CW'(MAX_SAMPLES));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_cnt[KW-1:0]] <= i_sample;
        end
        if (i_cmd.mem_read) begin
            r_rd <= r_mem[r_k];
        end
    end

    // run state
    logic [30:0]          r_per;
    logic [6:0]           r_npts;
    logic [6:0]           r_pt;
    logic signed [31:0]   r_cur;
    logic signed [U_W-1:0] r_r;
    logic signed [U_W-1:0] r_u;
    logic signed [CORDIC_W-1:0] r_x, r_y, r_z;
    logic [CORDIC_IW-1:0] r_it;
    logic [28:0]          r_w;
    logic signed [31:0]   r_sinc;
    logic signed [47:0]   r_prod;
    logic signed [SUM_W-1:0] r_sum;
    logic                 r_ovalid;
    logic signed [31:0]   r_oval;
    logic                 r_osat;
    logic                 r_olast;

    // divider operands
    logic [31:0]      tmag;
    logic [DIV_W-1:0] umag;
    logic [DIV_W-1:0] div_a, div_b;
    logic             div_done, div_rem_nz;
    logic [DIV_W-1:0] div_q;

    assign tmag = r_cur[31] ? 32'(-r_cur) : 32'(r_cur);
    assign umag = r_u[U_W-1] ? DIV_W'(-r_u) : DIV_W'(r_u);

    always_comb begin
        if (i_cmd.div_sinc) begin
            div_a = DIV_W'({r_w, 16'h0000});
            div_b = umag;
        end else begin
            div_a = DIV_W'({tmag, 16'h0000});
            div_b = DIV_W'(r_per);
        end
    end

    sir_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_time | i_cmd.div_sinc),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quotient (div_q),
        .o_rem_nz   (div_rem_nz)
    );

    // time quotient, rounded toward minus infinity
    logic [U_W-1:0] q_up;
    assign q_up = U_W'(div_q) + U_W'(div_rem_nz);

    // sinc argument pieces
    logic [15:0]          frac;
    logic [15:0]          gfold;
    logic [47:0]          ang_p;
    logic                 u_zero, frac_zero;
    logic signed [U_W-1:0] u_next;

    assign frac      = r_u[15:0];
    assign gfold     = (frac > 16'h8000) ? 16'(17'h10000 - {1'b0, frac}) : frac;
    assign ang_p     = 48'(gfold) * 48'(PI_Q30);
    assign u_zero    = (r_u == '0);
    assign frac_zero = (frac == '0);
    assign u_next    = r_r - $signed({1'b0, DIV_W'({r_k, 16'h0000})});

    // CORDIC step
    logic signed [CORDIC_W-1:0] sx, sy;
    logic [CORDIC_W-1:0]        at;
    assign sx = r_x >>> r_it;
    assign sy = r_y >>> r_it;
    assign at = atan_q30(r_it);

    // sine clamp and 1/pi scale
    logic [30:0] yc;
    logic [59:0] w_p;
    assign yc  = r_y[CORDIC_W-1] ? '0 :
                 (r_y > $signed(CORDIC_W'(Q30_ONE))) ? Q30_ONE : r_y[30:0];
    assign w_p = 60'(yc) * 60'(INV_PI_Q30);

    // sinc magnitude and sign
    logic [30:0] mag;
    logic        sneg;
    assign mag  = (div_q > DIV_W'(Q30_ONE)) ? Q30_ONE : div_q[30:0];
    assign sneg = r_u[16] ^ r_u[U_W-1];

    logic signed [47:0] w_prod;
    assign w_prod = 48'(r_rd) * 48'(r_sinc);

    // output rounding and saturation
    logic signed [SUM_W:0] rnd;
    logic signed [33:0]    v;
    logic                  sat;
    assign rnd = (SUM_W+1)'(r_sum) + (SUM_W+1)'(16384);
    assign v   = 34'(rnd >>> 15);
    assign sat = !((v[33:31] == 3'b000) || (v[33:31] == 3'b111));

    logic [32:0] t_next;
    assign t_next = 33'(r_cur) + {2'b00, r_cfg_step};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_pt     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.run_init) begin
                r_pt <= '0;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
                r_pt     <= r_pt + 1'b1;
                if (o_sts.pt_last) begin
                    r_cnt <= '0;
                end
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_init) begin
            r_per  <= (r_cfg_per == '0) ? 31'd1 : r_cfg_per;
            r_npts <= (r_cfg_cnt == '0) ? 7'd1 :
                      (r_cfg_cnt > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : r_cfg_cnt;
            r_cur  <= r_cfg_start;
        end
        if (i_cmd.r_capture) begin
            r_r   <= r_cur[31] ? -$signed(q_up) : $signed(U_W'(div_q));
            r_k   <= '0;
            r_sum <= '0;
        end
        if (i_cmd.mem_read) begin
            r_u <= u_next;
        end
        if (i_cmd.classify) begin
            r_x  <= CORDIC_W'(CORDIC_GAIN_Q30);
            r_y  <= '0;
            r_z  <= CORDIC_W'(ang_p[47:16]);
            r_it <= '0;
            if (u_zero) begin
                r_sinc <= 32'(Q30_ONE);
            end else if (frac_zero) begin
                r_sinc <= '0;
            end
        end
        if (i_cmd.cordic_step) begin
            r_it <= r_it + 1'b1;
            if (!r_z[CORDIC_W-1]) begin
                r_x <= r_x - sy;
                r_y <= r_y + sx;
                r_z <= r_z - $signed(at);
            end else begin
                r_x <= r_x + sy;
                r_y <= r_y - sx;
                r_z <= r_z + $signed(at);
            end
        end
        if (i_cmd.w_calc) begin
            r_w <= w_p[58:30];
        end
        if (i_cmd.sinc_capture) begin
            r_sinc <= sneg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
        if (i_cmd.term_mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.accumulate) begin
            r_sum <= r_sum + SUM_W'(r_prod >>> 15);
            r_k   <= r_k + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_oval  <= sat ? (v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : v[31:0];
            r_osat  <= sat;
            r_olast <= o_sts.pt_last;
            r_cur   <= (t_next[32:31] == 2'b01) ? 32'sh7FFF_FFFF : t_next[31:0];
        end
    end

    assign o_sts.div_done    = div_done;
    assign o_sts.special     = u_zero | frac_zero;
    assign o_sts.cordic_last = (r_it == CORDIC_IW'(CORDIC_STEPS - 1));
    assign o_sts.k_last      = ((CW'(r_k) + CW'(1)) == r_cnt);
    assign o_sts.pt_last     = ((r_pt + 7'd1) == r_npts);
    assign o_sts.out_busy    = r_ovalid && i_stall;

    assign o_valid       = r_ovalid;
    assign o_value       = r_oval;
    assign o_saturated   = r_osat;
    assign o_last_output = r_olast;

endmodule

@@ sv/sir_ctrl.sv @@
// Sequencer for load, per-point time divide and per-sample sinc evaluation.
module sir_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_last_sample,
    input  sir_pkg::t_sts  i_sts,
    output logic           o_stall,
    output sir_pkg::t_cmd  o_cmd
);
    import sir_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_TDIV, S_TWAIT, S_MEMRD, S_CLASS, S_CORDIC, S_WCALC,
        S_SDIV, S_SWAIT, S_MUL, S_ACC, S_OUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_valid;
                if (i_valid && i_last_sample) begin
                    o_cmd.run_init = 1'b1;
                    n_state = S_TDIV;
                end
            end
            S_TDIV: begin
                o_cmd.div_time = 1'b1;
                n_state = S_TWAIT;
            end
            S_TWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.r_capture = 1'b1;
                    n_state = S_MEMRD;
                end
            end
            S_MEMRD: begin
                o_cmd.mem_read = 1'b1;
                n_state = S_CLASS;
            end
            S_CLASS: begin
                o_cmd.classify = 1'b1;
                n_state = i_sts.special ? S_MUL : S_CORDIC;
            end
            S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (i_sts.cordic_last) begin
                    n_state = S_WCALC;
                end
            end
            S_WCALC: begin
                o_cmd.w_calc = 1'b1;
                n_state = S_SDIV;
            end
            S_SDIV: begin
                o_cmd.div_sinc = 1'b1;
                n_state = S_SWAIT;
            end
            S_SWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.sinc_capture = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.term_mul = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.accumulate = 1'b1;
                n_state = i_sts.k_last ? S_OUT : S_MEMRD;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = i_sts.pt_last ? S_IDLE : S_TDIV;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

@@ sv/sinc_interpolation_reconstructor.sv @@
// Sinc interpolation reconstructor: top level.
// Samples (Q1.15) are stored one word per cycle while the block is idle; a word with
// last_sample set starts a run of out_count points at start_time, start_time+time_step, ...
// Each point runs the time divide and then, per stored sample, a 24-step CORDIC, the sinc
// divide, a multiply and an accumulate, or only the multiply and accumulate when the argument
// is an integer; the single shared bit-serial divider and the CORDIC loop set the run time.
// Input stall is high for the whole run. Config writes are always
// taken and must only happen while idle.
module sinc_interpolation_reconstructor #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_sample,
    input  logic               i_last_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_value,
    output logic               o_saturated,
    output logic               o_last_output
);
    import sir_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    sir_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_last_sample (i_last_sample),
        .i_sts         (sts),
        .o_stall       (o_stall),
        .o_cmd         (cmd)
    );

    sir_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_sample      (i_sample),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_value       (o_value),
        .o_saturated   (o_saturated),
        .o_last_output (o_last_output)
    );

    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last_sample) |=> o_stall)
        else $error("run did not start after last sample");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !sts.out_busy)
        else $error("output word overwritten");

    a_one_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.div_time && cmd.div_sinc))
        else $error("divider started twice");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_load && sts.pt_last) |=> (!o_stall && o_valid && o_last_output))
        else $error("run end mismatch");

endmodule

@@ dv/tb_sinc_interpolation_reconstructor.sv @@
// Self-checking testbench for the sinc interpolation reconstructor.
`timescale 1ns / 1ps

module tb_sinc_interpolation_reconstructor;
    import sir_pkg::*;

    localparam int      STORE_DEPTH = 32;
    localparam int      CYCLE_LIMIT = 10_000_000;
    localparam int      DRAIN_WAIT  = 60;
    localparam longint  T_MAX       = 64'sd2147483647;
    localparam longint  GAIN        = 64'sd652032874;
    localparam longint  PI_FIX      = 64'sd3373259426;
    localparam longint  INV_PI_FIX  = 64'sd341782638;
    localparam longint  ONE_Q30     = 64'sd1 << 30;

    typedef struct packed {
        logic signed [31:0] value;
        logic               saturated;
        logic               last_output;
    } t_point;

    typedef struct {
        bit                 is_cfg;
        logic [1:0]         idx;
        logic [31:0]        data;
        logic signed [15:0] sample;
        bit                 last;
        bit                 typed;
        logic signed [31:0] first_value;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_sample;
    logic               i_last_sample;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_value;
    logic               o_saturated;
    logic               o_last_output;

    // a small store keeps the overfill case short
    sinc_interpolation_reconstructor #(.MAX_SAMPLES(STORE_DEPTH)) u_top (.*);

    // predictor state
    logic [30:0]        period_reg;
    logic signed [31:0] start_reg;
    logic [30:0]        step_reg;
    logic [6:0]         count_reg;
    logic signed [15:0] samples [STORE_DEPTH];
    int                 n_stored;
    longint             atan_rom [24];

    t_point expected_points [$];
    int     n_fail = 0;
    int     n_checked = 0;
    int     n_runs;
    int     n_words;
    int     cycles = 0;
    bit     quiet;
    int     stall_left = 0;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic longint sinc_fix(input longint u);
        longint f, g, z, x, y, dx, dy, w, umag, mag;
        bit     odd, neg;
        if (u == 0) return ONE_Q30;
        f = u & 64'hFFFF;
        if (f == 0) return 0;
        odd = u[16];
        g = (f > 32768) ? 65536 - f : f;
        z = (g * PI_FIX) >>> 16;
        x = GAIN;
        y = 0;
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_rom[i];
            end else begin
                x += dx; y -= dy; z += atan_rom[i];
            end
        end
        if (y < 0) y = 0;
        if (y > ONE_Q30) y = ONE_Q30;
        w = (y * INV_PI_FIX) >>> 30;
        umag = (u < 0) ? -u : u;
        mag = (w <<< 16) / umag;
        if (mag > ONE_Q30) mag = ONE_Q30;
        neg = odd != (u < 0);
        return neg ? -mag : mag;
    endfunction

    // Store one word; a marked word queues the whole run of points.
    task automatic absorb_word(input logic signed [15:0] s, input bit last,
                               input bit typed, input logic signed [31:0] first_value);
        longint per, cnt, t, r, acc, v;
        t_point p;
        if (n_stored < STORE_DEPTH) begin
            samples[n_stored] = s;
            n_stored++;
        end
        if (!last) return;
        per = (period_reg == 0) ? 1 : longint'(period_reg);
        cnt = count_reg;
        if (cnt < 1) cnt = 1;
        if (cnt > MAX_POINTS) cnt = MAX_POINTS;
        t = start_reg;
        for (int i = 0; i < cnt; i++) begin
            if (t >= 0) r = (t * 65536) / per;
            else        r = -(((-t) * 65536 + per - 1) / per);
            acc = 0;
            for (int k = 0; k < n_stored; k++)
                acc += (longint'(samples[k]) * sinc_fix(r - longint'(k) * 65536)) >>> 15;
            v = (acc + 16384) >>> 15;
            p.saturated = 1'b0;
            if (v > T_MAX)        begin v = T_MAX;      p.saturated = 1'b1; end
            if (v < -T_MAX - 1)   begin v = -T_MAX - 1; p.saturated = 1'b1; end
            p.value = (i == 0 && typed) ? first_value : v[31:0];
            p.last_output = (i == cnt - 1);
            expected_points = {expected_points, p};
            t = t + longint'(step_reg);
            if (t > T_MAX) t = T_MAX;
        end
        n_stored = 0;
        n_runs++;
    endtask

    task automatic send_word(input logic signed [15:0] s, input bit last,
                             input bit typed, input logic signed [31:0] first_value);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sample      <= s;
        i_last_sample <= last;
        do @(posedge i_clk); while (o_stall);
        absorb_word(s, last, typed, first_value);
        n_words++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SAMPLE_PERIOD: period_reg = data[30:0];
            CFG_START_TIME:    start_reg  = data;
            CFG_TIME_STEP:     step_reg   = data[30:0];
            CFG_OUT_COUNT:     count_reg  = data[6:0];
        endcase
        @(posedge i_clk);
    endtask

    // result side: random stall bursts plus field checks
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_points.size() == 0) begin
                $error("unexpected word: value %0d", o_value);
                n_fail++;
            end else begin
                automatic t_point e = expected_points.pop_front();
                if (o_value !== e.value) begin
                    $error("value: expected %0d, got %0d", e.value, o_value);
                    n_fail++;
                end
                if (o_saturated !== e.saturated) begin
                    $error("saturated: expected %0b, got %0b", e.saturated, o_saturated);
                    n_fail++;
                end
                if (o_last_output !== e.last_output) begin
                    $error("last_output: expected %0b, got %0b", e.last_output, o_last_output);
                    n_fail++;
                end
                n_checked++;
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 6);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    t_row directed [] = '{
        // defaults after reset: t=0 lands on sample 0 exactly
        '{0, CFG_OUT_COUNT, 0, 16'sh4000, 1, 1, 32'sd16384},
        '{1, CFG_OUT_COUNT, 1, 0, 0, 0, 0},
        '{0, CFG_OUT_COUNT, 0, 16'sh7FFF, 1, 1, 32'sd32767},
        '{0, CFG_OUT_COUNT, 0, -16'sh8000, 1, 1, -32'sd32768},
        '{1, CFG_START_TIME, 32'h0000_8000, 0, 0, 0, 0},
        '{0, CFG_OUT_COUNT, 0, 16'sd1000, 0, 0, 0},
        '{0, CFG_OUT_COUNT, 0, -16'sd1000, 0, 0, 0},
        '{0, CFG_OUT_COUNT, 0, 16'sh7FFF, 1, 0, 0},
        // zero sample period acts as one
        '{1, CFG_SAMPLE_PERIOD, 0, 0, 0, 0, 0},
        '{1, CFG_START_TIME, 32'hFFFF_FFFF, 0, 0, 0, 0},
        '{0, CFG_OUT_COUNT, 0, 16'sd500, 1, 0, 0},
        // out_count zero acts as one
        '{1, CFG_OUT_COUNT, 0, 0, 0, 0, 0},
        '{0, CFG_OUT_COUNT, 0, 16'sd0, 1, 1, 32'sd0},
        // count above max, zero step, time near the top
        '{1, CFG_OUT_COUNT, 127, 0, 0, 0, 0},
        '{1, CFG_TIME_STEP, 0, 0, 0, 0, 0},
        '{1, CFG_SAMPLE_PERIOD, 32'h0001_0000, 0, 0, 0, 0},
        '{1, CFG_START_TIME, 32'h7FFF_0000, 0, 0, 0, 0},
        '{0, CFG_OUT_COUNT, 0, 16'sd100, 0, 0, 0},
        '{0, CFG_OUT_COUNT, 0, 16'sd200, 1, 0, 0},
        // most negative start time stepped by the largest time step
        '{1, CFG_OUT_COUNT, 3, 0, 0, 0, 0},
        '{1, CFG_TIME_STEP, 32'h7FFF_FFFF, 0, 0, 0, 0},
        '{1, CFG_START_TIME, 32'h8000_0000, 0, 0, 0, 0},
        '{0, CFG_OUT_COUNT, 0, -16'sd5, 0, 0, 0},
        '{0, CFG_OUT_COUNT, 0, 16'sd7, 1, 0, 0},
        '{1, CFG_SAMPLE_PERIOD, 32'h7FFF_FFFF, 0, 0, 0, 0}
    };

    initial begin
        int n, loads;
        logic signed [15:0] s;
        atan_rom = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
                     64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
                     64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
                     64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                     64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        period_reg = 31'd65536;
        start_reg  = 0;
        step_reg   = 31'd65536;
        count_reg  = 7'd64;
        n_stored = 0; n_runs = 0; n_words = 0;
        quiet = 0;
        i_rst_n = 1'b0; i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_sample = '0; i_last_sample = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                wait_idle();
                write_reg(directed[i].idx, directed[i].data);
            end else begin
                send_word(directed[i].sample, directed[i].last,
                          directed[i].typed, directed[i].first_value);
            end
        end
        // final directed load under the largest period
        send_word(16'sd1234, 1, 0, 0);

        loads = 0;
        while (n_words < 160) begin
            if ($urandom_range(0, 2) == 0) begin
                wait_idle();
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_SAMPLE_PERIOD, $urandom_range(0, 5) == 0 ?
                                 $urandom : $urandom_range(4096, 262144));
                    1: write_reg(CFG_START_TIME, $urandom_range(0, 5) == 0 ?
                                 $urandom : 32'($urandom_range(0, 1048576)) - 32'd262144);
                    2: write_reg(CFG_TIME_STEP, $urandom_range(0, 5) == 0 ?
                                 $urandom : $urandom_range(0, 131072));
                    default: write_reg(CFG_OUT_COUNT, $urandom_range(0, 7) == 0 ?
                                       $urandom_range(0, 127) : $urandom_range(1, 6));
                endcase
            end
            n = $urandom_range(0, 9) == 0 ? $urandom_range(7, 16) : $urandom_range(1, 5);
            if (n_words > 120) quiet = 1;
            for (int j = 0; j < n; j++) begin
                s = $urandom_range(0, 7) == 0 ? ($urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000)
                                              : 16'($urandom);
                send_word(s, j == n - 1, 0, 0);
            end
            loads++;
        end

        // overfill the store: extra words are dropped, the mark still starts a run
        wait_idle();
        write_reg(CFG_SAMPLE_PERIOD, 32'h0001_0000);
        write_reg(CFG_START_TIME, 32'h0000_0000);
        write_reg(CFG_TIME_STEP, 32'h0001_0000);
        write_reg(CFG_OUT_COUNT, 1);
        for (int j = 0; j < STORE_DEPTH + 6; j++)
            send_word(16'($urandom), j == STORE_DEPTH + 5, 0, 0);

        wait_idle();
        $display("Covered %0d input words in %0d runs, %0d points checked.",
                 n_words, n_runs, n_checked);
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sinc_interpolation_reconstructor.f @@
sv/sir_pkg.sv
sv/sir_div.sv
sv/sir_dp.sv
sv/sir_ctrl.sv
sv/sinc_interpolation_reconstructor.sv
dv/tb_sinc_interpolation_reconstructor.sv
